### sv/etfd_pkg.sv
// ----------------------------------------------------------------------------
// etfd_pkg
// Shared types, codes and scaling helpers for the engine telemetry decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package etfd_pkg;

    localparam logic [7:0] START_BYTE = 8'hFF;
    localparam logic [7:0] KIND_ERROR_BYTE = 8'h00;
    localparam logic [7:0] KIND_INFO_BYTE = 8'h20;

    localparam logic [1:0] KIND_TELEMETRY = 2'd0;
    localparam logic [1:0] KIND_ERROR = 2'd1;
    localparam logic [1:0] KIND_INFO = 2'd2;

    // frame position: 0 waits for start, 1..5 next byte slot
    localparam logic [2:0] POS_IDLE = 3'd0;
    localparam logic [2:0] POS_KIND = 3'd1;
    localparam logic [2:0] POS_D1 = 3'd2;
    localparam logic [2:0] POS_D2 = 3'd3;
    localparam logic [2:0] POS_D3 = 3'd4;
    localparam logic [2:0] POS_LAST = 3'd5;

    // byte*K/255 split as byte*Whole + byte*Frac/255, K = 255*Whole + Frac
    localparam logic [5:0] MV_WHOLE = 6'd32;
    localparam logic [7:0] MV_FRAC = 8'd140;
    localparam logic [5:0] MAXRPM_WHOLE = 6'd36;
    localparam logic [7:0] MAXRPM_FRAC = 8'd120;
    localparam logic [13:0] MAXRPM_BASE_MV = 14'd7000;

    localparam logic [17:0] RPM_PER_COUNT = 18'd500;
    localparam logic [14:0] TEMP_PER_COUNT = 15'd46;
    localparam logic [14:0] TEMP_OFFSET = 15'd500;

    typedef struct packed {
        logic [7:0] kind;
        logic [7:0] d1;
        logic [7:0] d2;
        logic [7:0] d3;
        logic [7:0] d4;
    } frame_t;

    typedef struct packed {
        logic [5:0]         pad;
        logic               bldc_present;
        logic [13:0]        max_rpm_mv;
        logic [13:0]        battery_mv;
        logic [13:0]        idle_mv;
        logic [13:0]        output_mv;
        logic [7:0]         throttle_half_pct;
        logic signed [14:0] exhaust_temp_tenths;
        logic signed [17:0] rpm;
        logic [2:0]         error_code;
        logic [2:0]         engine_state;
        logic [1:0]         ops_mode;
    } out_data_t;

    // round(b*(255*whole+frac)/255); remainder part divided via (y+1+(y>>8))>>8
    function automatic logic [13:0] mv_scale(
        input logic [7:0] b,
        input logic [5:0] whole,
        input logic [7:0] frac
    );
        logic [15:0] y;
        logic [15:0] q;
        y = 16'({8'd0, b} * {8'd0, frac}) + 16'd127;
        q = (y + 16'd1 + (y >> 8)) >> 8;
        return 14'({6'd0, b} * {8'd0, whole}) + q[13:0];
    endfunction

endpackage

`default_nettype wire

### sv/engine_telemetry_frame_decoder.sv
// ----------------------------------------------------------------------------
// engine_telemetry_frame_decoder
// Serial engine telemetry frames in, one decoded engine record per frame out.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle. A 0xFF byte (re)starts a frame; the
// kind byte and four data bytes follow, and the record reaches the master
// side through the frame register, then decode into the record register.
// The record holds its values between frames; unknown mode, state or error
// codes keep the previous value. The byte input stalls only when a completed
// frame is waiting behind a record not yet taken.
// ----------------------------------------------------------------------------
`default_nettype none

module engine_telemetry_frame_decoder (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // [7:0] rx_byte
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [111:0]       m_tdata,   // ops_mode, engine_state, error_code, rpm,
                                          // exhaust_temp_tenths, throttle_half_pct,
                                          // output_mv, idle_mv, battery_mv,
                                          // max_rpm_mv, bldc_present, zero pad
    output logic [1:0]         m_tuser    // [1:0] frame_kind
);
    import etfd_pkg::*;

    frame_t    frame;
    logic      frame_valid;
    logic      frame_take;
    out_data_t m_data;

    etfd_framer u_framer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .frame       (frame),
        .frame_valid (frame_valid),
        .frame_take  (frame_take)
    );

    etfd_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .frame       (frame),
        .frame_valid (frame_valid),
        .frame_take  (frame_take),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_kind      (m_tuser),
        .m_data      (m_data)
    );

    assign m_tdata = m_data;

endmodule

`default_nettype wire

### sv/etfd_framer.sv
// ----------------------------------------------------------------------------
// etfd_framer
// Byte framing: start-byte sync, capture of kind and four data bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module etfd_framer (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [7:0]      s_tdata,
    output etfd_pkg::frame_t     frame,
    output logic                 frame_valid,
    input  wire logic            frame_take
);
    import etfd_pkg::*;

    logic [2:0] pos_reg;
    logic       frame_valid_reg;
    logic [7:0] kind_reg;
    logic [7:0] d1_reg;
    logic [7:0] d2_reg;
    logic [7:0] d3_reg;
    frame_t     frame_reg;
    logic       accept;
    logic       is_start;
    logic       frame_done;

    assign s_tready = !frame_valid_reg || frame_take;
    assign accept = s_tvalid && s_tready;
    assign is_start = (s_tdata == START_BYTE);
    assign frame_done = accept && !is_start && (pos_reg == POS_LAST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_IDLE;
            frame_valid_reg <= 1'b0;
        end else begin
            if (frame_done) begin
                frame_valid_reg <= 1'b1;
            end else if (frame_take) begin
                frame_valid_reg <= 1'b0;
            end
            if (accept) begin
                if (is_start) begin
                    pos_reg <= POS_KIND;
                end else if (pos_reg == POS_LAST) begin
                    pos_reg <= POS_IDLE;
                end else if (pos_reg != POS_IDLE) begin
                    pos_reg <= pos_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !is_start) begin
            case (pos_reg)
                POS_KIND: kind_reg <= s_tdata;
                POS_D1:   d1_reg <= s_tdata;
                POS_D2:   d2_reg <= s_tdata;
                POS_D3:   d3_reg <= s_tdata;
                POS_LAST: begin
                    frame_reg <= '{kind: kind_reg, d1: d1_reg, d2: d2_reg,
                                   d3: d3_reg, d4: s_tdata};
                end
                default: ;
            endcase
        end
    end

    assign frame = frame_reg;
    assign frame_valid = frame_valid_reg;

endmodule

`default_nettype wire

### sv/etfd_decode.sv
// ----------------------------------------------------------------------------
// etfd_decode
// Frame decode into the held engine record, which is the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module etfd_decode (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire etfd_pkg::frame_t  frame,
    input  wire logic              frame_valid,
    output logic                   frame_take,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [1:0]             m_kind,
    output etfd_pkg::out_data_t    m_data
);
    import etfd_pkg::*;

    logic       out_valid_reg;
    logic [1:0] kind_reg;
    out_data_t  held_reg;
    out_data_t  held_next;
    logic [1:0] kind_next;

    assign frame_take = frame_valid && (!out_valid_reg || m_tready);

    always_comb begin
        held_next = held_reg;
        held_next.pad = '0;
        kind_next = KIND_TELEMETRY;
        case (frame.kind)
            KIND_ERROR_BYTE: begin
                kind_next = KIND_ERROR;
                for (int k = 6; k >= 0; k--) begin
                    if (frame.d1[k]) begin
                        held_next.error_code = 3'(k + 1);
                    end
                end
                held_next.rpm = '1;
                held_next.exhaust_temp_tenths =
                    15'({7'd0, frame.d2} * TEMP_PER_COUNT) - TEMP_OFFSET;
                held_next.throttle_half_pct = frame.d3;
                held_next.output_mv = mv_scale(frame.d4, MV_WHOLE, MV_FRAC);
            end
            KIND_INFO_BYTE: begin
                kind_next = KIND_INFO;
                held_next.idle_mv = mv_scale(frame.d1, MV_WHOLE, MV_FRAC);
                held_next.battery_mv = mv_scale(frame.d2, MV_WHOLE, MV_FRAC);
                held_next.bldc_present = frame.d3[0];
                held_next.max_rpm_mv = MAXRPM_BASE_MV +
                    mv_scale(frame.d4, MAXRPM_WHOLE, MAXRPM_FRAC);
            end
            default: begin
                case (frame.kind[2:0])
                    3'd1:    held_next.ops_mode = 2'd1;
                    3'd2:    held_next.ops_mode = 2'd2;
                    3'd4:    held_next.ops_mode = 2'd3;
                    default: ;
                endcase
                case (frame.kind[7:3])
                    5'd1:    held_next.engine_state = 3'd1;
                    5'd2:    held_next.engine_state = 3'd2;
                    5'd4:    held_next.engine_state = 3'd3;
                    5'd8:    held_next.engine_state = 3'd4;
                    5'd12:   held_next.engine_state = 3'd5;
                    5'd28:   held_next.engine_state = 3'd6;
                    default: ;
                endcase
                held_next.rpm = 18'({10'd0, frame.d1} * RPM_PER_COUNT);
                held_next.exhaust_temp_tenths =
                    15'({7'd0, frame.d2} * TEMP_PER_COUNT) - TEMP_OFFSET;
                held_next.throttle_half_pct = frame.d3;
                held_next.output_mv = mv_scale(frame.d4, MV_WHOLE, MV_FRAC);
                held_next.error_code = 3'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            kind_reg <= KIND_TELEMETRY;
            held_reg <= '0;
        end else begin
            if (frame_take) begin
                out_valid_reg <= 1'b1;
                kind_reg <= kind_next;
                held_reg <= held_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_kind = kind_reg;
    assign m_data = held_reg;

endmodule

`default_nettype wire

### sv/etfd_checker.sv
// ----------------------------------------------------------------------------
// etfd_checker
// Port-level checks on the decoded record stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module etfd_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_tvalid,
    input wire logic          s_tready,
    input wire logic [7:0]    s_tdata,
    input wire logic          m_tvalid,
    input wire logic          m_tready,
    input wire logic [111:0]  m_tdata,
    input wire logic [1:0]    m_tuser
);
    import etfd_pkg::*;

    out_data_t rec;
    assign rec = m_tdata;

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled beat changed");

    a_error_rpm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_ERROR |-> rec.rpm == '1)
        else $error("error record without rpm of -1");

    a_telem_clears_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_TELEMETRY |-> rec.error_code == 3'd0)
        else $error("telemetry record with error set");

    a_maxrpm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> rec.max_rpm_mv == 14'd0 || rec.max_rpm_mv >= MAXRPM_BASE_MV)
        else $error("max rpm voltage out of range");

endmodule

bind engine_telemetry_frame_decoder etfd_checker u_etfd_checker (.*);

`default_nettype wire
